/* hdl/vgmd_pkg.sv */
// Package: shared types, constants and decode functions for the VGM command stream deframer.
`timescale 1ns / 1ps
package vgmd_pkg;

  localparam logic [31:0] BASE_OFFSET_RESET = 32'd64;
  localparam int MAX_RECORDS = 3;
  localparam int QUEUE_DEPTH = 8;

  typedef enum logic [3:0] {
    KIND_FIXED   = 4'd0,
    KIND_MIXER   = 4'd1,
    KIND_BLOCK   = 4'd2,
    KIND_RAMWR   = 4'd3,
    KIND_DAC     = 4'd4,
    KIND_LEGACY  = 4'd5,
    KIND_UNKNOWN = 4'd6,
    KIND_END     = 4'd7,
    KIND_ERROR   = 4'd8
  } kind_t;

  typedef enum logic [8:0] {
    PH_OPCODE = 9'b000000001,
    PH_SKIP   = 9'b000000010,
    PH_MIXER  = 9'b000000100,
    PH_BMARK  = 9'b000001000,
    PH_BTYPE  = 9'b000010000,
    PH_BLEN   = 9'b000100000,
    PH_RMARK  = 9'b001000000,
    PH_RTYPE  = 9'b010000000,
    PH_RHEAD  = 9'b100000000
  } phase_t;

  localparam logic [0:0] CFG_VERSION = 1'd0;
  localparam logic [0:0] CFG_BASE    = 1'd1;

  localparam logic [7:0] OP_END    = 8'h66;
  localparam logic [7:0] OP_BLOCK  = 8'h67;
  localparam logic [7:0] OP_RAMWR  = 8'h68;
  localparam logic [7:0] OP_MIXER  = 8'h4f;
  localparam logic [7:0] MARK_BYTE = 8'h66;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  fixed_entry;
    logic [7:0]  opcode;
    logic [31:0] start_offset;
    logic [7:0]  sub_type;
    logic [2:0]  block_class;
    logic [30:0] payload_length;
    logic        last_of_run;
  } rec_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] entry;
    logic [2:0] cnt;
  } fix_t;

  function automatic fix_t fixed_lookup(input logic [7:0] op);
    fix_t r;
    r = '{hit: 1'b1, entry: 6'd0, cnt: 3'd0};
    if (op == 8'h30) r = '{1'b1, 6'd0, 3'd1};
    else if (op >= 8'h31 && op <= 8'h3e) r = '{1'b1, 6'd1, 3'd1};
    else if (op == 8'h3f) r = '{1'b1, 6'd2, 3'd1};
    else if (op == 8'h50) r = '{1'b1, 6'd3, 3'd1};
    else if (op == 8'h51) r = '{1'b1, 6'd4, 3'd2};
    else if (op == 8'h52 || op == 8'h53) r = '{1'b1, 6'd5, 3'd2};
    else if (op >= 8'h54 && op <= 8'h55) r = '{1'b1, 6'(op - 8'h54 + 8'd6), 3'd2};
    else if (op == 8'h56 || op == 8'h57) r = '{1'b1, 6'd8, 3'd2};
    else if (op == 8'h58 || op == 8'h59) r = '{1'b1, 6'd9, 3'd2};
    else if (op >= 8'h5a && op <= 8'h5d) r = '{1'b1, 6'(op - 8'h5a + 8'd10), 3'd2};
    else if (op == 8'h5e || op == 8'h5f) r = '{1'b1, 6'd14, 3'd2};
    else if (op == 8'h61) r = '{1'b1, 6'd15, 3'd2};
    else if (op == 8'h62 || op == 8'h63) r = '{1'b1, 6'd16, 3'd0};
    else if (op == 8'h64) r = '{1'b1, 6'd17, 3'd3};
    else if (op >= 8'h70 && op <= 8'h7f) r = '{1'b1, 6'd18, 3'd0};
    else if (op >= 8'h80 && op <= 8'h8f) r = '{1'b1, 6'd19, 3'd0};
    else if (op == 8'ha0) r = '{1'b1, 6'd20, 3'd2};
    else if (op >= 8'ha1 && op <= 8'haf) r = '{1'b1, 6'd21, 3'd2};
    else if (op >= 8'hb0 && op <= 8'hbf) r = '{1'b1, 6'(op - 8'hb0 + 8'd22), 3'd2};
    else if (op >= 8'hc0 && op <= 8'hc8) r = '{1'b1, 6'(op - 8'hc0 + 8'd38), 3'd3};
    else if (op >= 8'hc9 && op <= 8'hcf) r = '{1'b1, 6'd47, 3'd3};
    else if (op >= 8'hd0 && op <= 8'hd6) r = '{1'b1, 6'(op - 8'hd0 + 8'd48), 3'd3};
    else if (op >= 8'hd7 && op <= 8'hdf) r = '{1'b1, 6'd55, 3'd3};
    else if (op == 8'he0) r = '{1'b1, 6'd56, 3'd4};
    else if (op == 8'he1) r = '{1'b1, 6'd57, 3'd4};
    else if (op >= 8'he2) r = '{1'b1, 6'd58, 3'd4};
    else r = '{1'b0, 6'd0, 3'd0};
    return r;
  endfunction

  function automatic logic [3:0] dac_len(input logic [2:0] i);
    logic [3:0] r;
    case (i)
      3'd0: r = 4'd4;
      3'd1: r = 4'd4;
      3'd2: r = 4'd5;
      3'd3: r = 4'd10;
      3'd4: r = 4'd1;
      3'd5: r = 4'd4;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] unknown_len(input logic [3:0] hi);
    logic [2:0] r;
    case (hi)
      4'd3, 4'd4: r = 3'd1;
      4'd5, 4'd10, 4'd11: r = 3'd2;
      4'd12, 4'd13: r = 3'd3;
      4'd14, 4'd15: r = 3'd4;
      4'd0, 4'd1, 4'd2, 4'd6, 4'd7, 4'd8, 4'd9: r = 3'd0;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/vgmd_out_fifo.sv */
// Result queue: holds up to three records per byte plus spare, drains one word per cycle while out_ready is high.
`timescale 1ns / 1ps
module vgmd_out_fifo #(
  parameter int Depth = vgmd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  vgmd_pkg::rec_t   push0,
  input  vgmd_pkg::rec_t   push1,
  input  vgmd_pkg::rec_t   push2,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output vgmd_pkg::rec_t   out_rec
);
  localparam int Aw = $clog2(Depth);

  vgmd_pkg::rec_t mem [Depth];
  logic [Aw-1:0] wr_ptr;
  logic [Aw-1:0] rd_ptr;
  logic [Aw:0]   fill;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = fill != '0;
  assign out_rec   = mem[rd_ptr];
  assign can_take  = (fill + (Aw+1)'(push_count)) <=
                     (Aw+1)'(Depth - vgmd_pkg::MAX_RECORDS);

  always_ff @(posedge clk) begin
    if (push_count > 2'd0) mem[wr_ptr] <= push0;
    if (push_count > 2'd1) mem[wr_ptr + Aw'(1)] <= push1;
    if (push_count > 2'd2) mem[wr_ptr + Aw'(2)] <= push2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + Aw'(push_count);
      if (pop) rd_ptr <= rd_ptr + Aw'(1);
      fill <= fill + (Aw+1)'(push_count) - (Aw+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= (Aw+1)'(Depth))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> $past(can_take) || $past(rst))
    else $error("push without room");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && push_count == 2'd0) |=> out_valid)
    else $error("record lost");
endmodule

/* hdl/vgmd_parser.sv */
// Parser: one byte per cycle while take is high, decodes commands and produces up to three records.
`timescale 1ns / 1ps
module vgmd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 is_last,
  input  logic                 version_at_least_160,
  input  logic [31:0]          stream_base_offset,
  output logic [1:0]           push_count,
  output vgmd_pkg::rec_t       push0,
  output vgmd_pkg::rec_t       push1,
  output vgmd_pkg::rec_t       push2
);
  vgmd_pkg::phase_t phase, phase_next;
  logic [7:0]  cur_op, cur_op_next;
  logic [31:0] skip, skip_next;
  logic [31:0] gather, gather_next;
  logic [7:0]  held, held_next;
  logic [31:0] pos;
  logic [31:0] cstart, cstart_next;
  logic        stopped, stopped_next;

  vgmd_pkg::rec_t r [3];
  logic [1:0] n;
  vgmd_pkg::rec_t rec_reg [3];
  logic [1:0] n_reg;

  vgmd_pkg::fix_t fx;
  logic [7:0]  op;
  logic        op_valid;
  logic [31:0] glen;
  logic [30:0] len31;
  logic [24:0] rlen;
  logic [2:0]  cls;

  function automatic vgmd_pkg::rec_t mk(input vgmd_pkg::kind_t k, input logic [5:0] e,
                                        input logic [7:0] o, input logic [31:0] s,
                                        input logic [7:0] st, input logic [2:0] c,
                                        input logic [30:0] l);
    vgmd_pkg::rec_t x;
    x.kind = k; x.fixed_entry = e; x.opcode = o; x.start_offset = s;
    x.sub_type = st; x.block_class = c; x.payload_length = l; x.last_of_run = 1'b0;
    return x;
  endfunction

  always_comb begin
    phase_next   = phase;
    cur_op_next  = cur_op;
    skip_next    = skip;
    gather_next  = gather;
    held_next    = held;
    cstart_next  = cstart;
    stopped_next = stopped;
    n = 2'd0;
    r[0] = '0; r[1] = '0; r[2] = '0;
    op = data_byte;
    op_valid = 1'b0;
    glen = '0; len31 = '0; rlen = '0; cls = '0;
    fx = vgmd_pkg::fixed_lookup(data_byte);

    case (phase)
      vgmd_pkg::PH_OPCODE: begin
        cstart_next = pos;
        op_valid = 1'b1;
      end
      vgmd_pkg::PH_SKIP: begin
        if (skip <= 32'd1) begin
          skip_next = '0;
          phase_next = vgmd_pkg::PH_OPCODE;
        end else begin
          skip_next = skip - 32'd1;
        end
      end
      vgmd_pkg::PH_MIXER: begin
        r[0] = mk(vgmd_pkg::KIND_MIXER, '0, cur_op, cstart + stream_base_offset,
                  data_byte, '0, '0);
        n = 2'd1;
        phase_next = vgmd_pkg::PH_OPCODE;
      end
      vgmd_pkg::PH_BMARK: begin
        if (data_byte == vgmd_pkg::MARK_BYTE) begin
          phase_next = vgmd_pkg::PH_BTYPE;
        end else begin
          r[0] = mk(vgmd_pkg::KIND_UNKNOWN, '0, cur_op, cstart + stream_base_offset,
                    '0, '0, '0);
          n = 2'd1;
          cstart_next = pos;
          op_valid = 1'b1;
        end
      end
      vgmd_pkg::PH_BTYPE: begin
        held_next = data_byte;
        gather_next = '0;
        skip_next = 32'd4;
        phase_next = vgmd_pkg::PH_BLEN;
      end
      vgmd_pkg::PH_BLEN: begin
        case (skip[2:0])
          3'd4: glen = {gather[31:8], data_byte};
          3'd3: glen = {gather[31:16], data_byte, gather[7:0]};
          3'd2: glen = {gather[31:24], data_byte, gather[15:0]};
          default: glen = {data_byte, gather[23:0]};
        endcase
        gather_next = glen;
        if (skip > 32'd1) begin
          skip_next = skip - 32'd1;
        end else begin
          len31 = glen[30:0];
          if (held <= 8'h3f) cls = 3'd0;
          else if (held <= 8'h7e) cls = 3'd1;
          else if (held == 8'h7f) cls = 3'd2;
          else if (held <= 8'hbf) cls = 3'd3;
          else cls = 3'd4;
          r[0] = mk(vgmd_pkg::KIND_BLOCK, '0, cur_op, cstart + stream_base_offset,
                    held, cls, len31);
          n = 2'd1;
          skip_next = {1'b0, len31};
          phase_next = (len31 != '0) ? vgmd_pkg::PH_SKIP : vgmd_pkg::PH_OPCODE;
        end
      end
      vgmd_pkg::PH_RMARK: begin
        if (data_byte != vgmd_pkg::MARK_BYTE) begin
          r[0] = mk(vgmd_pkg::KIND_ERROR, '0, cur_op, cstart + stream_base_offset,
                    data_byte, '0, '0);
          n = 2'd1;
          stopped_next = 1'b1;
          phase_next = vgmd_pkg::PH_OPCODE;
        end else begin
          phase_next = vgmd_pkg::PH_RTYPE;
        end
      end
      vgmd_pkg::PH_RTYPE: begin
        held_next = data_byte;
        gather_next = '0;
        skip_next = 32'd9;
        phase_next = vgmd_pkg::PH_RHEAD;
      end
      vgmd_pkg::PH_RHEAD: begin
        case (skip[3:0])
          4'd3: glen = {gather[31:8], data_byte};
          4'd2: glen = {gather[31:16], data_byte, gather[7:0]};
          4'd1: glen = {gather[31:24], data_byte, gather[15:0]};
          default: glen = gather;
        endcase
        gather_next = glen;
        if (skip > 32'd1) begin
          skip_next = skip - 32'd1;
        end else begin
          rlen = (glen[23:0] == '0) ? 25'h1000000 : {1'b0, glen[23:0]};
          r[0] = mk(vgmd_pkg::KIND_RAMWR, '0, cur_op, cstart + stream_base_offset,
                    held, '0, 31'(rlen));
          n = 2'd1;
          skip_next = 32'(rlen);
          phase_next = vgmd_pkg::PH_SKIP;
        end
      end
      default: phase_next = vgmd_pkg::PH_OPCODE;
    endcase

    if (op_valid) begin
      cur_op_next = op;
      phase_next = vgmd_pkg::PH_OPCODE;
      if (op == vgmd_pkg::OP_END) begin
        r[n] = mk(vgmd_pkg::KIND_END, '0, op, pos + stream_base_offset, '0, '0, '0);
        n = n + 2'd1;
        stopped_next = 1'b1;
      end else if (op == vgmd_pkg::OP_MIXER) begin
        phase_next = vgmd_pkg::PH_MIXER;
      end else if (fx.hit) begin
        r[n] = mk(vgmd_pkg::KIND_FIXED, fx.entry, op, pos + stream_base_offset,
                  '0, '0, 31'(fx.cnt));
        n = n + 2'd1;
        skip_next = 32'(fx.cnt);
        phase_next = (fx.cnt != '0) ? vgmd_pkg::PH_SKIP : vgmd_pkg::PH_OPCODE;
      end else if (op == vgmd_pkg::OP_BLOCK) begin
        phase_next = vgmd_pkg::PH_BMARK;
      end else if (op == vgmd_pkg::OP_RAMWR) begin
        phase_next = vgmd_pkg::PH_RMARK;
      end else if (op >= 8'h90 && op <= 8'h95) begin
        r[n] = mk(vgmd_pkg::KIND_DAC, '0, op, pos + stream_base_offset, '0, '0,
                  31'(vgmd_pkg::dac_len(op[2:0])));
        n = n + 2'd1;
        skip_next = 32'(vgmd_pkg::dac_len(op[2:0]));
        phase_next = vgmd_pkg::PH_SKIP;
      end else if (op >= 8'h40 && op <= 8'h4e) begin
        r[n] = mk(vgmd_pkg::KIND_LEGACY, '0, op, pos + stream_base_offset, '0, '0,
                  version_at_least_160 ? 31'd2 : 31'd1);
        n = n + 2'd1;
        skip_next = version_at_least_160 ? 32'd2 : 32'd1;
        phase_next = vgmd_pkg::PH_SKIP;
      end else begin
        r[n] = mk(vgmd_pkg::KIND_UNKNOWN, '0, op, pos + stream_base_offset, '0, '0,
                  31'(vgmd_pkg::unknown_len(op[7:4])));
        n = n + 2'd1;
        skip_next = 32'(vgmd_pkg::unknown_len(op[7:4]));
        phase_next = (vgmd_pkg::unknown_len(op[7:4]) != '0) ?
                     vgmd_pkg::PH_SKIP : vgmd_pkg::PH_OPCODE;
      end
    end

    if (is_last && !stopped_next) begin
      if (phase_next != vgmd_pkg::PH_OPCODE)
        r[n] = mk(vgmd_pkg::KIND_ERROR, '0, cur_op_next, cstart_next + stream_base_offset,
                  '0, '0, '0);
      else
        r[n] = mk(vgmd_pkg::KIND_ERROR, '0, '0, pos + 32'd1 + stream_base_offset,
                  '0, '0, '0);
      n = n + 2'd1;
      stopped_next = 1'b1;
      phase_next = vgmd_pkg::PH_OPCODE;
    end
    if (n != 2'd0) r[n - 2'd1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= vgmd_pkg::PH_OPCODE;
      cur_op  <= '0;
      skip    <= '0;
      gather  <= '0;
      held    <= '0;
      pos     <= '0;
      cstart  <= '0;
      stopped <= 1'b0;
      n_reg   <= '0;
    end else begin
      n_reg <= '0;
      if (take && !stopped) begin
        phase   <= phase_next;
        cur_op  <= cur_op_next;
        skip    <= skip_next;
        gather  <= gather_next;
        held    <= held_next;
        pos     <= pos + 32'd1;
        cstart  <= cstart_next;
        stopped <= stopped_next;
        n_reg   <= n;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_reg[0] <= r[0];
    rec_reg[1] <= r[1];
    rec_reg[2] <= r[2];
  end

  assign push_count = n_reg;
  assign push0 = rec_reg[0];
  assign push1 = rec_reg[1];
  assign push2 = rec_reg[2];

  assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("phase not one-hot");
  assert property (@(posedge clk) disable iff (rst) stopped |=> stopped)
    else $error("stop released");
  assert property (@(posedge clk) disable iff (rst) stopped |=> n_reg == 2'd0)
    else $error("record after stop");
  assert property (@(posedge clk) disable iff (rst)
    (phase == vgmd_pkg::PH_SKIP) |-> skip != '0)
    else $error("skip phase with zero count");
endmodule

/* hdl/vgm_command_stream_deframer_core.sv */
// Top level: VGM command stream deframer with config registers and result queue.
`timescale 1ns / 1ps
// Takes one stream byte per cycle while in_ready is high and yields one record per
// command (up to three records for one byte), reported at the opcode or last header
// byte. Payload and operand bytes pass at one per cycle with no record. A byte's
// records pass one register stage in the parser, then an eight-word queue that
// drains one word per cycle while out_ready is high. Input ready drops while the
// queue, counting the records still held in the parser register, has fewer than
// three free slots. After an end command, a bad ram write or the is_last byte,
// further bytes are taken and dropped until reset.
module vgm_command_stream_deframer_core #(
  parameter int QueueDepth = vgmd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [5:0]  fixed_entry,
  output logic [7:0]  opcode,
  output logic [31:0] start_offset,
  output logic [7:0]  sub_type,
  output logic [2:0]  block_class,
  output logic [30:0] payload_length,
  output logic        last_of_run
);
  logic        version_at_least_160;
  logic [31:0] stream_base_offset;
  logic        can_take;
  logic [1:0]  push_count;
  vgmd_pkg::rec_t push0, push1, push2, rec;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      version_at_least_160 <= 1'b0;
      stream_base_offset   <= vgmd_pkg::BASE_OFFSET_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        vgmd_pkg::CFG_VERSION: version_at_least_160 <= cfg_data[0];
        vgmd_pkg::CFG_BASE:    stream_base_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  vgmd_parser u_parser (
    .clk, .rst,
    .take(in_valid && in_ready),
    .data_byte, .is_last,
    .version_at_least_160, .stream_base_offset,
    .push_count, .push0, .push1, .push2
  );

  vgmd_out_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk, .rst,
    .push_count, .push0, .push1, .push2,
    .can_take, .out_valid, .out_ready, .out_rec(rec)
  );

  assign kind           = rec.kind;
  assign fixed_entry    = rec.fixed_entry;
  assign opcode         = rec.opcode;
  assign start_offset   = rec.start_offset;
  assign sub_type       = rec.sub_type;
  assign block_class    = rec.block_class;
  assign payload_length = rec.payload_length;
  assign last_of_run    = rec.last_of_run;
endmodule
